// ----- rtl/core/rpm_pkg.sv -----
// Shared types, constants and elaboration helpers for the random projection MAC.
`timescale 1ns / 1ps

package rpm_pkg;

    // Default parameter values
    localparam int DST_DIM_DEF     = 16;
    localparam int MAX_SRC_DIM_DEF = 128;

    // Field widths
    localparam int ELEM_W    = 16;
    localparam int VAL_W     = 24;
    localparam int IDX_W     = 4;
    localparam int SRC_LEN_W = 8;
    localparam int ACC_W     = 40;
    localparam int ACC_LO_W  = 20;
    localparam int LCG_W     = 31;

    localparam logic [SRC_LEN_W-1:0] SRC_LEN_RESET = 8'd64;

    // Coefficient generator: r = ((seed + i) * mult + inc) mod 2^31
    localparam logic [LCG_W-1:0] LCG_SEED = 31'd42;
    localparam logic [LCG_W-1:0] LCG_MULT = 31'd1103515245;
    localparam logic [LCG_W-1:0] LCG_INC  = 31'd12345;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;       // latch element, advance element count
        logic mac_issue;    // start one row update
        logic drain_issue;  // start one row readout
    } t_dp_cmd;

    // Datapath status back to the controller
    typedef struct packed {
        logic in_range;     // current position falls inside the source length
        logic mac_busy;     // row updates still in flight
        logic adv;          // readout pipe may move this cycle
        logic drain_busy;   // readout pipe or output register holds a word
    } t_dp_stat;

    // Integer square root, used only for elaboration-time constants.
    function automatic logic [32:0] isqrt64(input logic [63:0] x);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = 64'd0;
        hi = 64'd1 << 32;
        while ((hi - lo) > 64'd1) begin
            mid = lo + ((hi - lo) >> 1);
            if ((mid * mid) <= x) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        return lo[32:0];
    endfunction

endpackage

// ----- rtl/core/random_projection_mac.sv -----
// Top level of the streaming random projection multiply-accumulate block.
`timescale 1ns / 1ps
//
// Usage:
//   s_axis carries one source vector element per word (Q2.13 in tdata), tlast
//   on its final element. Each element updates DST_DIM row accumulators through
//   one shared multiplier, one row per cycle, and occupies the block through
//   accept, row sweep and the two-stage MAC pipe drain. Elements past the
//   effective source length are only counted. After the word marked tlast,
//   DST_DIM projected features leave on m_axis in row order: tdata = {index,
//   value}, tlast on the final row, tuser set when the element count differed
//   from source_length. Features leave one per cycle while m_axis_tready is
//   high; the four-stage scaling pipe simply holds when the receiver stalls,
//   and no feature is lost. s_axis_tready stays low until the last feature has
//   been taken.
//   i_cfg_we/i_cfg_wdata write source_length; write it only while idle.
//   Reset (i_rst_n low, synchronous) clears all accumulators, the element count
//   and sets source_length to 64.

module random_projection_mac #(
    parameter int DST_DIM     = rpm_pkg::DST_DIM_DEF,
    parameter int MAX_SRC_DIM = rpm_pkg::MAX_SRC_DIM_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: source_length
    input  logic        i_cfg_we,
    input  logic [rpm_pkg::SRC_LEN_W-1:0] i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] element
    input  logic        s_axis_tlast,   // last_element
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [23:0] feature_value, [27:24] feature_index, rest 0
    output logic        m_axis_tlast,   // last_feature
    output logic        m_axis_tuser    // [0] length_mismatch
);
    import rpm_pkg::*;

    localparam int ROW_W = (DST_DIM > 1) ? $clog2(DST_DIM) : 1;

    t_dp_cmd               w_cmd;
    t_dp_stat              w_stat;
    logic [ROW_W-1:0]      w_row;
    logic signed [VAL_W-1:0] w_value;
    logic [IDX_W-1:0]      w_index;

    // sequencer: accept handshake, row sweep, readout ordering
    rpm_ctrl #(
        .DST_DIM (DST_DIM)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tlast  (s_axis_tlast),
        .o_s_tready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_row      (w_row)
    );

    // arithmetic, accumulator memory and output register
    rpm_datapath #(
        .DST_DIM     (DST_DIM),
        .MAX_SRC_DIM (MAX_SRC_DIM)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_elem      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_cmd       (w_cmd),
        .i_row       (w_row),
        .o_stat      (w_stat),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_value     (w_value),
        .o_index     (w_index),
        .o_last_feat (m_axis_tlast),
        .o_mismatch  (m_axis_tuser)
    );

    // pack: value in the low bits, row index above it, zero fill to 32
    assign m_axis_tdata = {4'd0, w_index, w_value};

endmodule

// ----- rtl/core/rpm_ctrl.sv -----
// Sequencer for the random projection MAC: element accept, row sweep, readout.
`timescale 1ns / 1ps

module rpm_ctrl #(
    parameter int DST_DIM = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tlast,
    output logic              o_s_tready,
    input  rpm_pkg::t_dp_stat i_stat,
    output rpm_pkg::t_dp_cmd  o_cmd,
    output logic [((DST_DIM > 1) ? $clog2(DST_DIM) : 1)-1:0] o_row
);
    import rpm_pkg::*;

    localparam int ROW_W = (DST_DIM > 1) ? $clog2(DST_DIM) : 1;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(DST_DIM - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAC   = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_last, n_last;
    logic             w_accept;
    t_dp_cmd          w_cmd;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_last  = r_last;
        w_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    w_cmd.accept = 1'b1;
                    n_last       = i_s_tlast;
                    n_row        = '0;
                    if (i_stat.in_range) begin
                        n_state = ST_MAC;
                    end else if (i_s_tlast) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_MAC: begin
                w_cmd.mac_issue = 1'b1;
                if (r_row == LAST_ROW) begin
                    n_state = ST_WAIT;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            ST_WAIT: begin
                if (!i_stat.mac_busy) begin
                    n_row   = '0;
                    n_state = r_last ? ST_DRAIN : ST_IDLE;
                end
            end
            ST_DRAIN: begin
                if (i_stat.adv) begin
                    w_cmd.drain_issue = 1'b1;
                    if (r_row == LAST_ROW) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (!i_stat.drain_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_last  <= n_last;
        end
    end

    assign o_cmd = w_cmd;
    assign o_row = r_row;

`ifndef NO_ASSERTIONS
    // a new element never enters while either pipe still holds work
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (!i_stat.mac_busy && !i_stat.drain_busy))
        else $error("element accepted while pipes busy");

    // readout rows are only issued when the readout pipe can move
    a_drain_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.drain_issue |-> i_stat.adv)
        else $error("readout issued into a stalled pipe");
`endif

endmodule

// ----- rtl/core/rpm_datapath.sv -----
// Datapath: coefficient generator, shared MAC, accumulator memory, scaling pipe.
`timescale 1ns / 1ps

module rpm_datapath #(
    parameter int DST_DIM     = 16,
    parameter int MAX_SRC_DIM = 128
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [rpm_pkg::SRC_LEN_W-1:0]          i_cfg_wdata,
    input  logic signed [rpm_pkg::ELEM_W-1:0]      i_elem,
    input  logic                                   i_last,
    input  rpm_pkg::t_dp_cmd                       i_cmd,
    input  logic [((DST_DIM > 1) ? $clog2(DST_DIM) : 1)-1:0] i_row,
    output rpm_pkg::t_dp_stat                      o_stat,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [rpm_pkg::VAL_W-1:0]       o_value,
    output logic [rpm_pkg::IDX_W-1:0]              o_index,
    output logic                                   o_last_feat,
    output logic                                   o_mismatch
);
    import rpm_pkg::*;

    localparam int ROW_W  = (DST_DIM > 1) ? $clog2(DST_DIM) : 1;
    localparam int FLAT_W = $clog2(DST_DIM) + SRC_LEN_W;
    localparam int LEN_CAP = (MAX_SRC_DIM > 255) ? 255 : MAX_SRC_DIM;
    localparam logic [SRC_LEN_W-1:0] LEN_CAP_V = SRC_LEN_W'(LEN_CAP);
    localparam logic [ROW_W-1:0]     LAST_ROW  = ROW_W'(DST_DIM - 1);

    // 1/sqrt(DST_DIM) as unsigned Q1.16, rounded
    localparam logic [63:0] SQ_ARG  = (64'd1 << 34) / DST_DIM;
    localparam logic [32:0] SQ_ROOT = isqrt64(SQ_ARG);
    localparam logic signed [17:0] SCALE = 18'((SQ_ROOT + 33'd1) >> 1);

    localparam int SUM_W = ACC_W + 18;
    localparam int SHR_W = SUM_W - 31;
    localparam logic signed [SUM_W-1:0] RND     = SUM_W'(64'd1 << 30);
    localparam logic signed [SHR_W-1:0] SAT_MAX = SHR_W'(24'sh7FFFFF);
    localparam logic signed [SHR_W-1:0] SAT_MIN = SHR_W'(24'sh800000);

    // configuration and element state
    logic [SRC_LEN_W-1:0] r_src_len;
    logic [SRC_LEN_W-1:0] r_count;
    logic [SRC_LEN_W-1:0] r_len;
    logic                 r_mismatch;
    logic signed [ELEM_W-1:0] r_elem;
    logic [FLAT_W-1:0]    r_flat;

    logic [SRC_LEN_W-1:0] w_len;
    logic [SRC_LEN_W-1:0] w_count_inc;

    assign w_len       = (r_src_len > LEN_CAP_V) ? LEN_CAP_V : r_src_len;
    assign w_count_inc = (r_count == '1) ? r_count : r_count + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_len  <= SRC_LEN_RESET;
            r_count    <= '0;
            r_mismatch <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_src_len <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                if (i_last) begin
                    r_mismatch <= (w_count_inc != r_src_len);
                    r_count    <= '0;
                end else begin
                    r_count <= w_count_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_elem <= i_elem;
            r_len  <= w_len;
            r_flat <= FLAT_W'(r_count);
        end else if (i_cmd.mac_issue) begin
            r_flat <= r_flat + FLAT_W'(r_len);
        end
    end

    // coefficient for the row being issued
    logic [LCG_W-1:0] w_seed_sum;
    logic [LCG_W-1:0] w_lcg;
    assign w_seed_sum = LCG_W'(r_flat) + LCG_SEED;
    assign w_lcg      = w_seed_sum * LCG_MULT + LCG_INC;

    // accumulator memory, one read port, one write port
    logic [ACC_W-1:0]   mem [DST_DIM];
    logic [DST_DIM-1:0] r_row_valid;
    logic [ACC_W-1:0]   r_rd_data;
    logic               r_rd_zero;
    logic               w_rd_en;
    logic [ACC_W-1:0]   w_rd_acc;

    assign w_rd_en  = i_cmd.mac_issue || i_cmd.drain_issue;
    assign w_rd_acc = r_rd_zero ? '0 : r_rd_data;

    // MAC pipe
    logic                     r_m1_v, r_m2_v;
    logic [ROW_W-1:0]         r_m1_row, r_m2_row;
    logic signed [ELEM_W-1:0] r_coef;
    logic signed [31:0]       r_prod;
    logic [ACC_W-1:0]         r_m2_acc;
    logic [ACC_W-1:0]         w_acc_sum;

    assign w_acc_sum = r_m2_acc + ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= mem[i_row];
            r_rd_zero <= !r_row_valid[i_row];
        end
        if (r_m2_v) begin
            mem[r_m2_row] <= w_acc_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_m1_v      <= 1'b0;
            r_m2_v      <= 1'b0;
        end else begin
            r_m1_v <= i_cmd.mac_issue;
            r_m2_v <= r_m1_v;
            if (r_m2_v) begin
                r_row_valid[r_m2_row] <= 1'b1;
            end else if (i_cmd.drain_issue) begin
                r_row_valid[i_row] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1_row <= i_row;
        r_coef   <= {~w_lcg[LCG_W-1], w_lcg[LCG_W-2:15]};
        r_m2_row <= r_m1_row;
        r_prod   <= r_elem * r_coef;
        r_m2_acc <= w_rd_acc;
    end

    // scaling pipe, stalls as a whole on the output register
    logic                     w_adv;
    logic                     r_d1_v, r_d2_v, r_d3_v, r_out_v;
    logic [ROW_W-1:0]         r_d1_row, r_d2_row, r_d3_row, r_out_row;
    logic signed [ACC_W-ACC_LO_W-1:0] w_hi;
    logic signed [ACC_LO_W:0] w_lo;
    logic signed [ACC_W-ACC_LO_W+17:0] r_p_hi;
    logic signed [ACC_LO_W+18:0]       r_p_lo;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SHR_W-1:0]  w_shr;
    logic signed [VAL_W-1:0]  w_sat;
    logic signed [VAL_W-1:0]  r_out_val;

    assign w_adv = !r_out_v || i_ready;
    assign w_hi  = w_rd_acc[ACC_W-1:ACC_LO_W];
    assign w_lo  = {1'b0, w_rd_acc[ACC_LO_W-1:0]};
    assign w_shr = r_sum[SUM_W-1:31];

    always_comb begin
        priority if (w_shr > SAT_MAX) begin
            w_sat = VAL_W'(SAT_MAX);
        end else if (w_shr < SAT_MIN) begin
            w_sat = VAL_W'(SAT_MIN);
        end else begin
            w_sat = VAL_W'(w_shr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_v  <= 1'b0;
            r_d2_v  <= 1'b0;
            r_d3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_d1_v  <= i_cmd.drain_issue;
            r_d2_v  <= r_d1_v;
            r_d3_v  <= r_d2_v;
            r_out_v <= r_d3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d1_row  <= i_row;
            r_d2_row  <= r_d1_row;
            r_p_hi    <= w_hi * SCALE;
            r_p_lo    <= w_lo * SCALE;
            r_d3_row  <= r_d2_row;
            r_sum     <= (SUM_W'(r_p_hi) <<< ACC_LO_W) + SUM_W'(r_p_lo) + RND;
            r_out_row <= r_d3_row;
            r_out_val <= w_sat;
        end
    end

    assign o_valid     = r_out_v;
    assign o_value     = r_out_val;
    assign o_index     = IDX_W'(r_out_row);
    assign o_last_feat = (r_out_row == LAST_ROW);
    assign o_mismatch  = r_mismatch;

    assign o_stat.in_range   = (r_count < w_len);
    assign o_stat.mac_busy   = r_m1_v || r_m2_v;
    assign o_stat.adv        = w_adv;
    assign o_stat.drain_busy = r_d1_v || r_d2_v || r_d3_v || r_out_v;

`ifndef NO_ASSERTIONS
    // row updates and readout never share the read data register
    a_no_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m1_v || r_m2_v) |-> !(r_d1_v || r_d2_v || r_d3_v))
        else $error("row update overlaps readout");

    // a row read out starts the next vector from zero
    a_row_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.drain_issue |=> !r_row_valid[$past(i_row)])
        else $error("accumulator not cleared after readout");
`endif

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for random_projection_mac: stream driver, feature monitor, predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int ROWS    = rpm_pkg::DST_DIM_DEF;
    localparam int MAX_LEN = rpm_pkg::MAX_SRC_DIM_DEF;

    // Coefficient generator, r = ((seed + i) * mult + inc) mod 2^31
    localparam bit [31:0] COEF_SEED = 32'd42;
    localparam bit [31:0] COEF_MULT = 32'd1103515245;
    localparam bit [31:0] COEF_INC  = 32'd12345;

    // round(2^16 / sqrt(16)), unsigned Q1.16
    localparam longint ROW_SCALE  = 64'sd16384;
    localparam longint ROUND_HALF = 64'sd1 << 30;
    localparam longint FEAT_MAX   = 64'sd8388607;
    localparam longint FEAT_MIN   = -64'sd8388608;

    // Give the block twice an element sweep before a config write.
    localparam int SETTLE_CYCLES = 2 * ROWS + 8;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_LIMIT   = 20000;

    typedef struct packed {
        logic signed [15:0] value;
        logic               last;
    } t_element_word;

    typedef struct packed {
        logic [23:0] value;
        logic [3:0]  index;
        logic        last;
        logic        mismatch;
    } t_feature;

    // DUT ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [rpm_pkg::SRC_LEN_W-1:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [15:0] element
    logic        s_axis_tlast = 1'b0; // last_element
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [23:0] feature_value, [27:24] feature_index
    logic        m_axis_tlast;        // last_feature
    logic        m_axis_tuser;        // [0] length_mismatch

    // Stimulus and expectation stores
    t_element_word pending_words[$];
    t_feature      expected_features[$];
    t_element_word next_word;
    t_feature      want;

    // Predictor state: mirrors the block's accumulators, count and length register
    bit [39:0] row_acc [ROWS];
    bit [7:0]  element_count = '0;
    bit [7:0]  source_length = rpm_pkg::SRC_LEN_RESET;

    // Idle percentages, written by the stimulus process only
    int unsigned send_gap_pct = 0;
    int unsigned recv_gap_pct = 0;

    // Long receiver hold-off: requested by stimulus, counted in the monitor
    bit hold_request = 1'b0;
    bit hold_started = 1'b0;
    int hold_left = 0;

    int mismatch_count = 0;

    random_projection_mac i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Q0.15 matrix coefficient for flat index row * length + position
    function automatic longint row_coeff(input int unsigned flat);
        bit [31:0] r;
        r = (COEF_SEED + flat) * COEF_MULT + COEF_INC;
        return longint'({1'b0, r[30:15]}) - 64'sd32768;
    endfunction

    // Fold one accepted element into the rows; on the last one queue all features.
    function automatic void project_element(input logic signed [15:0] x, input logic is_last);
        int unsigned len;
        longint term;
        longint acc;
        longint scaled;
        t_feature f;
        len = (source_length < MAX_LEN) ? source_length : MAX_LEN;
        // past the effective length an element only bumps the count
        if (element_count < len) begin
            for (int d = 0; d < ROWS; d++) begin
                term = longint'(x) * row_coeff(d * len + element_count);
                row_acc[d] = row_acc[d] + term[39:0];   // 40-bit wrap
            end
        end
        if (element_count != 8'hFF) begin
            element_count++;
        end
        if (is_last) begin
            for (int d = 0; d < ROWS; d++) begin
                acc = longint'(signed'(row_acc[d]));
                scaled = (acc * ROW_SCALE + ROUND_HALF) >>> 31;   // floor
                if (scaled > FEAT_MAX) begin
                    scaled = FEAT_MAX;
                end
                if (scaled < FEAT_MIN) begin
                    scaled = FEAT_MIN;
                end
                f.value    = scaled[23:0];
                f.index    = d[3:0];
                f.last     = (d == ROWS - 1);
                f.mismatch = (element_count != source_length);
                expected_features.push_back(f);
                row_acc[d] = '0;
            end
            element_count = '0;
        end
    endfunction

    // Input side: present words from the pending queue, idle at random,
    // and feed the predictor with each word the block takes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                project_element(s_axis_tdata, s_axis_tlast);
            end
            // only move on when the current word is gone or none is shown
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    next_word = pending_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_word.value;
                    s_axis_tlast  <= next_word.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side: random backpressure plus one long hold-off; every feature
    // taken is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_features.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: unexpected feature: value %0d index %0d last %0b flag %0b",
                                 $realtime, $signed(m_axis_tdata[23:0]), m_axis_tdata[27:24],
                                 m_axis_tlast, m_axis_tuser);
                    end
                end else begin
                    want = expected_features.pop_front();
                    if (m_axis_tdata[23:0] !== want.value || m_axis_tdata[27:24] !== want.index
                            || m_axis_tlast !== want.last || m_axis_tuser !== want.mismatch) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $write("%0t: feature mismatch: expected value %0d index %0d",
                                   $realtime, $signed(want.value), want.index);
                            $write(" last %0b flag %0b,", want.last, want.mismatch);
                            $display(" got value %0d index %0d last %0b flag %0b",
                                     $signed(m_axis_tdata[23:0]), m_axis_tdata[27:24],
                                     m_axis_tlast, m_axis_tuser);
                        end
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (hold_request && !hold_started) begin
                hold_started <= 1'b1;
                hold_left <= LONG_HOLD;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);
            end
        end
    end

    // Run limit, several times the slowest legal run
    initial begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [15:0] pick_element();
        logic [15:0] corners [5];
        corners = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF};
        if ($urandom_range(7) == 0) begin
            return corners[$urandom_range(4)];
        end
        return 16'($urandom);
    endfunction

    function automatic void queue_word(input logic [15:0] v, input logic is_last);
        pending_words.push_back('{value: v, last: is_last});
    endfunction

    function automatic void queue_vector(input int n);
        for (int k = 0; k < n; k++) begin
            queue_word(pick_element(), k == n - 1);
        end
    endfunction

    // Mostly exact-length vectors, some cut short, some overlong.
    function automatic int pick_vector_len(input int len);
        int k;
        k = $urandom_range(9);
        if (k < 7) begin
            return len;
        end else if (k == 7) begin
            return $urandom_range(1, len);
        end
        return len + $urandom_range(1, 3);
    endfunction

    // Sender pause: everything taken and every feature back
    task automatic wait_drained();
        while (pending_words.size() != 0 || s_axis_tvalid || expected_features.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_source_length(input int unsigned v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v[7:0];
        source_length = v[7:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        int len;
        int n;
        int random_words;
        int waited;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_gap_pct <= 36;
        recv_gap_pct <= 55;

        // --- directed ---
        // Short vector against the reset length of 64: flags a mismatch,
        // coefficients indexed with stride 64.
        queue_word(16'h7FFF, 1'b0);
        queue_word(16'h8000, 1'b0);
        queue_word(16'h0000, 1'b1);

        // Minimum length: single element, then one excess element.
        write_source_length(1);
        queue_word(16'h8000, 1'b1);
        queue_word(16'h7FFF, 1'b0);
        queue_word(16'hFFFF, 1'b1);
        // Overlong vector: only the first element counts.
        queue_vector(5);

        // Zero length: nothing accumulates, all features zero, mismatch set.
        write_source_length(0);
        queue_word(16'h1234, 1'b0);
        queue_word(16'hFFFB, 1'b1);

        // Extremes in a well-formed vector, then a bit-pattern vector cut short.
        write_source_length(4);
        queue_word(16'h7FFF, 1'b0);
        queue_word(16'h8000, 1'b0);
        queue_word(16'h0001, 1'b0);
        queue_word(16'hFFFF, 1'b1);
        queue_word(16'h5555, 1'b0);
        queue_word(16'hAAAA, 1'b1);

        // --- random, three idling regimes ---
        for (int regime = 0; regime < 3; regime++) begin
            random_words = 0;
            if (regime == 1) begin
                send_gap_pct <= 55;
                recv_gap_pct <= 36;
            end else if (regime == 2) begin
                send_gap_pct <= 0;
                recv_gap_pct <= 0;
            end
            if (regime == 0) begin
                // back-to-back short vectors while the receiver holds off,
                // so the block fills and stalls its input
                write_source_length(2);
                for (int v = 0; v < 6; v++) begin
                    n = pick_vector_len(2);
                    queue_vector(n);
                    random_words += n;
                end
                hold_request <= 1'b1;
            end
            while (random_words < 24) begin
                len = $urandom_range(1, 8);
                write_source_length(len);
                repeat ($urandom_range(2, 4)) begin
                    n = pick_vector_len(len);
                    queue_vector(n);
                    random_words += n;
                end
            end
        end

        // Largest lengths with short vectors: stride 128 rows, and register
        // maximum 255 capped to 128 (both flag a mismatch).
        write_source_length(MAX_LEN);
        queue_vector(3);
        write_source_length(255);
        queue_vector(3);

        // --- wind down ---
        while (pending_words.size() != 0 || s_axis_tvalid) begin
            @(posedge i_clk);
        end
        waited = 0;
        while (expected_features.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_features.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/rpm_pkg.sv
rtl/core/rpm_ctrl.sv
rtl/core/rpm_datapath.sv
rtl/core/random_projection_mac.sv
bench/testbench.sv
